### sv/assert_macros.svh
// Assertion macros used by the port checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ITP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define ITP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/itp_pkg.sv
// Shared types and constants of the inversion table to permutation decoder.
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

   // Default capacity of the count tree.
   localparam int MAX_VALUES_DEF = 1024;

   // Fixed field widths.
   localparam int VALUE_W = 11;
   localparam int RANK_W  = 10;
   localparam int CFG_W   = 11;
   localparam int TDATA_W = 16;

   localparam int REQ_PAD_W = TDATA_W - RANK_W;
   localparam int RSP_PAD_W = TDATA_W - VALUE_W;

   // Register reset value of value_count.
   localparam logic [CFG_W-1:0] VALUE_COUNT_RST = 11'd1024;

   // Controller states.
   typedef enum logic [2:0] {
      S_INIT,
      S_SWEEP,
      S_IDLE,
      S_CHECK,
      S_DESCEND,
      S_SEND
   } itp_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic init;        // capture n, reset root and sweep pointers
      logic sweep;       // write one rebuilt tree node
      logic load_item;   // capture the incoming rank
      logic begin_desc;  // start the descent at the root
      logic step;        // descend one tree level
      logic set_error;   // record an error result
      logic send;        // move the result into the output register
   } itp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;  // sweep writes its last node this cycle
      logic too_large;   // rank is not below the unused value count
      logic leaf;        // descent reaches a leaf this cycle
      logic out_free;    // output register can take a word
   } itp_sts_type;

endpackage

`default_nettype wire

### sv/itp_ctrl.sv
// Controller state machine of the inversion table to permutation decoder.
`timescale 1ns / 1ps
`default_nettype none

module itp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_start,
   input  wire itp_pkg::itp_sts_type sts,
   output logic                      req_tready,
   output itp_pkg::itp_cmd_type      cmd
);

   itp_pkg::itp_state_type state_ff, state_in;
   logic                   pend_ff, pend_in;
   logic                   accept;

   // State and pending-item registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itp_pkg::S_INIT;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   assign accept  = req_tvalid && req_tready;
   assign pend_in = pend_ff || accept;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         itp_pkg::S_INIT: begin
            cmd.init = 1'b1;
            state_in = itp_pkg::S_SWEEP;
         end
         itp_pkg::S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = pend_ff ? itp_pkg::S_CHECK : itp_pkg::S_IDLE;
            end
         end
         itp_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = req_start ? itp_pkg::S_INIT : itp_pkg::S_CHECK;
            end
         end
         itp_pkg::S_CHECK: begin
            if (sts.too_large) begin
               cmd.set_error = 1'b1;
               state_in      = itp_pkg::S_SEND;
            end else begin
               cmd.begin_desc = 1'b1;
               state_in       = itp_pkg::S_DESCEND;
            end
         end
         itp_pkg::S_DESCEND: begin
            cmd.step = 1'b1;
            if (sts.leaf) begin
               state_in = itp_pkg::S_SEND;
            end
         end
         itp_pkg::S_SEND: begin
            // Hand off the result and take the next word in the same cycle.
            if (sts.out_free) begin
               cmd.send   = 1'b1;
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.load_item = 1'b1;
                  state_in      = req_start ? itp_pkg::S_INIT : itp_pkg::S_CHECK;
               end else begin
                  state_in = itp_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = itp_pkg::S_INIT;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/itp_datapath.sv
// Count tree memory, sweep and descent datapath of the permutation decoder.
`timescale 1ns / 1ps
`default_nettype none

module itp_datapath #(
   parameter int MAX_VALUES = itp_pkg::MAX_VALUES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire itp_pkg::itp_cmd_type         cmd,
   output itp_pkg::itp_sts_type              sts,
   input  wire logic [itp_pkg::RANK_W-1:0]   req_rank,
   input  wire logic                         csr_we,
   input  wire logic [itp_pkg::CFG_W-1:0]    csr_wdata,
   input  wire logic                         rsp_tready,
   output logic                              rsp_tvalid,
   output logic [itp_pkg::VALUE_W-1:0]       rsp_value,
   output logic                              rsp_error
);

   localparam int LEAVES = 1 << $clog2(MAX_VALUES);
   localparam int LEVELS = $clog2(LEAVES);
   localparam int ADDR_W = LEVELS + 1;
   localparam int DEPTH  = 2 * LEAVES;
   localparam int CNT_W  = $clog2(MAX_VALUES + 1);
   localparam int CMP_W  = (CNT_W > itp_pkg::RANK_W) ? CNT_W : itp_pkg::RANK_W;
   localparam int SW_W   = LEVELS + 1;

   // Count tree; the root lives in a register, nodes 2 and up live here.
   logic [CNT_W-1:0] tree_mem [DEPTH];

   logic [itp_pkg::CFG_W-1:0]   vcount_ff, vcount_in;
   logic [CNT_W-1:0]            n_ff, n_in;
   logic [CNT_W-1:0]            root_ff, root_in;
   logic [ADDR_W-1:0]           sw_addr_ff, sw_addr_in;
   logic [LEVELS-1:0]           sw_lo_ff, sw_lo_in;
   logic [LEVELS-1:0]           sw_size_ff, sw_size_in;
   logic [itp_pkg::RANK_W-1:0]  rank_ff, rank_in;
   logic [ADDR_W-1:0]           node_ff, node_in;
   logic [CNT_W-1:0]            cur_ff, cur_in;
   logic [CNT_W-1:0]            rd_data_ff;
   logic [itp_pkg::VALUE_W-1:0] res_val_ff, res_val_in;
   logic                        res_err_ff, res_err_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [itp_pkg::VALUE_W-1:0] rsp_val_ff, rsp_val_in;
   logic                        rsp_err_ff, rsp_err_in;

   logic [CNT_W-1:0]  n_eff;
   logic [SW_W-1:0]   sw_n_x, sw_lo_x, sw_size_x, sw_diff, sw_lo_sum;
   logic [CNT_W-1:0]  sweep_val;
   logic [CMP_W-1:0]  rank_x, rd_x, root_x;
   logic              go_left;
   logic [ADDR_W-1:0] child;
   logic [CNT_W-1:0]  child_cnt;
   logic [31:0]       leaf_val;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  wr_data;

   // Clamp the register to the tree capacity.
   assign n_eff = (32'(vcount_ff) > 32'(MAX_VALUES)) ? CNT_W'(MAX_VALUES)
                                                     : CNT_W'(vcount_ff);

   // Rebuilt count of the node under the sweep pointer.
   assign sw_n_x    = SW_W'(n_ff);
   assign sw_lo_x   = SW_W'(sw_lo_ff);
   assign sw_size_x = SW_W'(sw_size_ff);
   assign sw_diff   = sw_n_x - sw_lo_x;
   assign sw_lo_sum = sw_lo_x + sw_size_x;
   always_comb begin
      if (sw_n_x <= sw_lo_x) begin
         sweep_val = '0;
      end else if (sw_diff > sw_size_x) begin
         sweep_val = CNT_W'(sw_size_x);
      end else begin
         sweep_val = CNT_W'(sw_diff);
      end
   end

   // One descent step: pick the child from the right child's count.
   assign rank_x    = CMP_W'(rank_ff);
   assign rd_x      = CMP_W'(rd_data_ff);
   assign root_x    = CMP_W'(root_ff);
   assign go_left   = rd_x <= rank_x;
   assign child     = {node_ff[ADDR_W-2:0], ~go_left};
   assign child_cnt = go_left ? (cur_ff - rd_data_ff) : rd_data_ff;
   assign leaf_val  = 32'(child[LEVELS-1:0]) + 32'd1;

   // Memory port selection.
   assign rd_addr = cmd.begin_desc ? ADDR_W'(3) : {child[ADDR_W-2:0], 1'b1};
   assign wr_en   = cmd.sweep || cmd.step;
   assign wr_addr = cmd.sweep ? sw_addr_ff : child;
   assign wr_data = cmd.sweep ? sweep_val : (child_cnt - CNT_W'(1));

   // Status to the controller.
   assign sts.sweep_last = (sw_addr_ff == {ADDR_W{1'b1}});
   assign sts.too_large  = rank_x >= root_x;
   assign sts.leaf       = child[ADDR_W-1];
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   // Next values of the datapath registers.
   always_comb begin
      vcount_in    = csr_we ? csr_wdata : vcount_ff;
      n_in         = n_ff;
      root_in      = root_ff;
      sw_addr_in   = sw_addr_ff;
      sw_lo_in     = sw_lo_ff;
      sw_size_in   = sw_size_ff;
      rank_in      = rank_ff;
      node_in      = node_ff;
      cur_in       = cur_ff;
      res_val_in   = res_val_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_val_in   = rsp_val_ff;
      rsp_err_in   = rsp_err_ff;

      // Start a rebuild at the first inner node below the root.
      if (cmd.init) begin
         n_in       = n_eff;
         root_in    = n_eff;
         sw_addr_in = ADDR_W'(2);
         sw_lo_in   = '0;
         sw_size_in = LEVELS'(LEAVES / 2);
      end

      // Advance the sweep pointer, dropping to the next level at its end.
      if (cmd.sweep) begin
         sw_addr_in = sw_addr_ff + ADDR_W'(1);
         if (sw_lo_sum == SW_W'(LEAVES)) begin
            sw_lo_in   = '0;
            sw_size_in = sw_size_ff >> 1;
         end else begin
            sw_lo_in = sw_lo_sum[LEVELS-1:0];
         end
      end

      if (cmd.load_item) begin
         rank_in = req_rank;
      end

      if (cmd.begin_desc) begin
         node_in = ADDR_W'(1);
         cur_in  = root_ff;
         root_in = root_ff - CNT_W'(1);
      end

      if (cmd.step) begin
         node_in = child;
         cur_in  = child_cnt;
         if (go_left) begin
            rank_in = itp_pkg::RANK_W'(rank_x - rd_x);
         end
         if (child[ADDR_W-1]) begin
            res_val_in = leaf_val[itp_pkg::VALUE_W-1:0];
            res_err_in = 1'b0;
         end
      end

      if (cmd.set_error) begin
         res_val_in = '0;
         res_err_in = 1'b1;
      end

      // Load the output register.
      if (cmd.send) begin
         rsp_valid_in = 1'b1;
         rsp_val_in   = res_val_ff;
         rsp_err_in   = res_err_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= itp_pkg::VALUE_COUNT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      root_ff    <= root_in;
      sw_addr_ff <= sw_addr_in;
      sw_lo_ff   <= sw_lo_in;
      sw_size_ff <= sw_size_in;
      rank_ff    <= rank_in;
      node_ff    <= node_in;
      cur_ff     <= cur_in;
      res_val_ff <= res_val_in;
      res_err_ff <= res_err_in;
      rsp_val_ff <= rsp_val_in;
      rsp_err_ff <= rsp_err_in;
   end

   // Tree memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= tree_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_val_ff;
   assign rsp_error  = rsp_err_ff;

endmodule

`default_nettype wire

### sv/inversion_table_to_permutation.sv
// Top level of the inversion table to permutation decoder.
//
// Input words (req_) carry one inversion table entry, last position first:
// greater_count in req_tdata and start_req in req_tuser. A word with start_req
// set first makes values 1..n available again. Result words (rsp_) carry the
// decoded value (1-based, 0 on error) in rsp_tdata and the error flag in
// rsp_tuser. The csr_ port writes value_count (n); it is used at the next start
// (reset sets it back to 1024), and a value above MAX_VALUES counts as MAX_VALUES.
// Let L be MAX_VALUES rounded up to a power of two: the count tree has L leaves
// and is walked one level per cycle through the read port of its memory. A word
// without start passes a check state, one descent step per level and a send
// state; a rank not below the count of unused values goes from check to send
// as an error result. Words are decoded one at a time. A start first rebuilds
// the tree, one node per cycle; after reset the same rebuild runs with
// value_count = 1024 and req_tready low. A result waits in an output register
// while rsp_tready is low; one more word may be taken and decoded meanwhile, and
// its result then holds, with req_tready low, until that register frees.
`timescale 1ns / 1ps
`default_nettype none

module inversion_table_to_permutation #(
   parameter int MAX_VALUES = itp_pkg::MAX_VALUES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Input words
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [itp_pkg::TDATA_W-1:0]   req_tdata,  // [9:0] greater_count
   input  wire logic                          req_tuser,  // [0] start_req
   // Result words
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [itp_pkg::TDATA_W-1:0]        rsp_tdata,  // [10:0] value
   output logic                               rsp_tuser,  // [0] error
   // Configuration
   input  wire logic                          csr_we,
   input  wire logic [itp_pkg::CFG_W-1:0]     csr_wdata
);

   itp_pkg::itp_cmd_type        cmd;
   itp_pkg::itp_sts_type        sts;
   logic [itp_pkg::VALUE_W-1:0] rsp_value;

   itp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_start  (req_tuser),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   itp_datapath #(
      .MAX_VALUES (MAX_VALUES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_rank   (req_tdata[itp_pkg::RANK_W-1:0]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_value  (rsp_value),
      .rsp_error  (rsp_tuser)
   );

   // Pad the value up to whole bytes.
   assign rsp_tdata = {{itp_pkg::RSP_PAD_W{1'b0}}, rsp_value};

endmodule

`default_nettype wire

### sv/itp_checker.sv
// Port checker of the permutation decoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module itp_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [itp_pkg::TDATA_W-1:0] rsp_tdata,
   input wire logic                        rsp_tuser
);

   // A stalled result word holds.
   `ITP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed while stalled")

   // An error word carries value zero.
   `ITP_ASSERT(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0, "error word with nonzero value")

   // A good word carries a value of one or more.
   `ITP_ASSERT(a_ok_nonzero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata != '0, "good word with value zero")

   // req_tready is low in the cycle after a word is taken.
   `ITP_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready, "input taken on back-to-back cycles")

   // Reset empties the output register.
   `ITP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind inversion_table_to_permutation itp_checker u_itp_checker (.*);

`default_nettype wire
